// ===== rtl/core/histeq_pkg.sv =====
package histeq_pkg;

	localparam int BIN_COUNT  = 256;
	localparam int COUNT_BITS = 24;
	localparam int PIX_BITS   = 8;
	localparam int BIN_BITS   = 8;
	localparam int CUM_BITS   = 32;
	localparam int QUO_BITS   = 10;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic FUNC_COUNT = 1'b0;
	localparam logic FUNC_MAP   = 1'b1;

	typedef struct packed {
		logic                func;
		logic [PIX_BITS-1:0] pixel;
		logic                frame_end;
	} in_item_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] mapped_pixel;
		logic                out_last;
	} out_item_t;

endpackage

// ===== rtl/core/histeq_if.sv =====
interface histeq_in_if;
	logic                 valid;
	logic                 ready;
	histeq_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface histeq_out_if;
	logic                  valid;
	logic                  ready;
	histeq_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/histeq_div.sv =====
// restoring divider, one quotient bit per cycle
module histeq_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [histeq_pkg::CUM_BITS+9:0]      num,
	input  logic [histeq_pkg::CUM_BITS:0]        den,
	output logic                                 done,
	output logic [histeq_pkg::QUO_BITS-1:0]      quo
);
	localparam int NB = histeq_pkg::CUM_BITS + 10;
	localparam int SB = $clog2(NB + 1);

	logic [NB-1:0]                   num_q;
	logic [histeq_pkg::CUM_BITS:0]   den_q;
	logic [histeq_pkg::CUM_BITS+1:0] rem_q;
	logic [SB-1:0]                   cnt_q;
	logic                            busy_q;
	logic [histeq_pkg::CUM_BITS+1:0] trial;
	logic                            fits;

	assign trial = {rem_q[histeq_pkg::CUM_BITS:0], num_q[NB-1]};
	assign fits  = trial >= {1'b0, den_q};

	// shift, compare and subtract
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
				cnt_q  <= SB'(NB);
			end else if (busy_q) begin
				rem_q <= fits ? trial - {1'b0, den_q} : trial;
				num_q <= {num_q[NB-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SB'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// quotient lands in num_q; values above 1023 clamp below anyway
	assign quo = (|num_q[NB-1:histeq_pkg::QUO_BITS]) ? '1 : num_q[histeq_pkg::QUO_BITS-1:0];
endmodule

// ===== rtl/core/histogram_equalizer.sv =====
// channel | dir | payload
// in      | in  | func, pixel, frame_end
// out     | out | mapped_pixel, out_last
// count and map items: a pixel every cycle while in_ch.ready is high, registered memory read.
// a count item with frame_end starts the table build: a running-sum pass, then per bin
// a wait, a divide and a write state, running the 42-step division when the entry
// needs it; no items are taken.
// after reset an init pass over all 256 bins clears the bins and loads the identity table.
// output register with a skid stage lets items flow while a result waits.
module histogram_equalizer (
	input  logic         clk,
	input  logic         arst_n,
	histeq_in_if.sink    in_ch,
	histeq_out_if.source out_ch
);
	localparam int CB = histeq_pkg::COUNT_BITS;
	localparam int BB = histeq_pkg::BIN_BITS;

	typedef enum logic [2:0] {ST_INIT, ST_RUN, ST_CUM, ST_DIV, ST_WAIT, ST_WR} state_t;

	logic [CB-1:0] bins_mem [histeq_pkg::BIN_COUNT];
	logic [histeq_pkg::CUM_BITS-1:0] cum_mem [histeq_pkg::BIN_COUNT];
	logic [histeq_pkg::PIX_BITS-1:0] map_mem [histeq_pkg::BIN_COUNT];

	state_t        state_q;
	logic [BB:0]   idx_q;
	logic [CB-1:0] total_q;
	logic [histeq_pkg::CUM_BITS-1:0] acc_q, min_q, cum_rd_q;
	logic          have_min_q;
	logic          idle_q;

	// count pipeline
	logic          cnt_v_s1;
	logic [BB-1:0] cnt_a_s1;
	logic          cnt_last_s1;
	logic [CB-1:0] bin_rd_s1;
	logic          fwd_v_s2;
	logic [BB-1:0] fwd_a_s2;
	logic [CB-1:0] fwd_d_s2;
	logic [CB-1:0] bin_cur, bin_new;

	// map pipeline and output stage
	logic          map_v_s1, map_last_s1;
	logic [histeq_pkg::PIX_BITS-1:0] map_rd_s1;
	histeq_pkg::out_item_t out_q, skid_q;
	logic          out_v_q, skid_v_q;

	logic          take, accept;
	logic [histeq_pkg::CUM_BITS-1:0] acc_next, den;
	logic          div_start, div_done;
	logic [histeq_pkg::QUO_BITS-1:0] quo;
	logic [histeq_pkg::PIX_BITS-1:0] entry;

	// hold off while a map item in flight is about to land in the skid stage
	assign take   = state_q == ST_RUN && !skid_v_q && !cnt_last_s1
		&& !(map_v_s1 && out_v_q && !out_ch.ready);
	assign in_ch.ready = take;
	assign accept = in_ch.valid && take;

	// read-modify-write with forwarding for back-to-back pixels in the same bin
	assign bin_cur = (fwd_v_s2 && fwd_a_s2 == cnt_a_s1) ? fwd_d_s2 : bin_rd_s1;
	assign bin_new = (bin_cur == histeq_pkg::COUNT_MAX) ? bin_cur : bin_cur + 1'b1;

	assign acc_next = acc_q + {{(histeq_pkg::CUM_BITS-CB){1'b0}}, bin_rd_s1};
	assign den = (total_q > min_q[CB-1:0]) ? {{(histeq_pkg::CUM_BITS-CB){1'b0}},
		total_q - min_q[CB-1:0]} : histeq_pkg::CUM_BITS'(1);

	histeq_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(42'(cum_rd_q - min_q) * 42'd510 + 42'(den)),
		.den({den, 1'b0}), .done(div_done), .quo(quo)
	);

	always_comb begin
		if (min_q[CB-1:0] == total_q)
			entry = idx_q[BB-1:0];
		else if (cum_rd_q < min_q)
			entry = '0;
		else if (quo > 10'd255)
			entry = 8'd255;
		else
			entry = quo[7:0];
	end
	assign div_start = state_q == ST_DIV && min_q[CB-1:0] != total_q && cum_rd_q >= min_q;

	// memories
	always_ff @(posedge clk) begin
		bin_rd_s1 <= bins_mem[in_ch.data.pixel];
		if (state_q == ST_CUM)
			bin_rd_s1 <= bins_mem[idx_q[BB-1:0]];
		if (state_q == ST_INIT)
			bins_mem[idx_q[BB-1:0]] <= '0;
		else if (state_q == ST_CUM && idx_q != '0)
			bins_mem[idx_q[BB-1:0] - 1'b1] <= '0;
		else if (cnt_v_s1)
			bins_mem[cnt_a_s1] <= bin_new;
		if (state_q == ST_CUM && idx_q != '0)
			cum_mem[idx_q[BB-1:0] - 1'b1] <= acc_next;
		cum_rd_q <= cum_mem[idx_q[BB-1:0]];
		map_rd_s1 <= map_mem[in_ch.data.pixel];
		if (state_q == ST_INIT)
			map_mem[idx_q[BB-1:0]] <= idx_q[BB-1:0];
		else if (state_q == ST_WR)
			map_mem[idx_q[BB-1:0]] <= entry;
		fwd_a_s2 <= cnt_a_s1;
		fwd_d_s2 <= bin_new;
		cnt_a_s1 <= in_ch.data.pixel;
		map_last_s1 <= in_ch.data.frame_end;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT; idx_q <= '0; total_q <= '0; acc_q <= '0;
			min_q <= '0; have_min_q <= 1'b0; idle_q <= 1'b0;
			cnt_v_s1 <= 1'b0; cnt_last_s1 <= 1'b0; fwd_v_s2 <= 1'b0; map_v_s1 <= 1'b0;
		end else begin
			cnt_v_s1 <= accept && in_ch.data.func == histeq_pkg::FUNC_COUNT;
			cnt_last_s1 <= accept && in_ch.data.func == histeq_pkg::FUNC_COUNT
				&& in_ch.data.frame_end;
			map_v_s1 <= accept && in_ch.data.func == histeq_pkg::FUNC_MAP;
			fwd_v_s2 <= cnt_v_s1;
			idle_q <= 1'b0;
			if (accept && in_ch.data.func == histeq_pkg::FUNC_COUNT
				&& total_q != histeq_pkg::COUNT_MAX)
				total_q <= total_q + 1'b1;
			case (state_q)
				ST_INIT: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q[BB-1:0] == '1) begin
						idx_q <= '0; state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cnt_last_s1) begin
						state_q <= ST_CUM; idx_q <= '0; acc_q <= '0; have_min_q <= 1'b0;
					end
				end
				ST_CUM: begin
					// read at idx, accumulate the previous read
					if (idx_q != '0) begin
						acc_q <= acc_next;
						if (!have_min_q && acc_next != '0) begin
							min_q <= acc_next; have_min_q <= 1'b1;
						end
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q[BB]) begin
						idx_q <= '0; state_q <= ST_WAIT; idle_q <= 1'b1;
					end
					if (idx_q == '0) min_q <= '0;
				end
				ST_WAIT: state_q <= ST_DIV;
				ST_DIV: state_q <= div_start ? ST_WAIT : ST_WR;
				ST_WR: begin
					// pass through the idle wait state for the next running-sum read
					idx_q <= idx_q + 1'b1;
					state_q <= ST_WAIT;
					idle_q <= 1'b1;
					if (idx_q[BB-1:0] == '1) begin
						idx_q <= '0; total_q <= '0; state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_INIT;
			endcase
			// wait for divider after start
			if (state_q == ST_WAIT && !idle_q && !div_done) state_q <= ST_WAIT;
			if (state_q == ST_WAIT && div_done) state_q <= ST_WR;
			if (state_q == ST_DIV && div_start) idle_q <= 1'b0;
			if (state_q == ST_DIV && !div_start) state_q <= ST_WR;
		end
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0; skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || out_ch.ready) begin
				if (skid_v_q) begin
					out_q <= skid_q; out_v_q <= 1'b1; skid_v_q <= 1'b0;
				end else begin
					out_v_q <= map_v_s1;
					out_q <= '{mapped_pixel: map_rd_s1, out_last: map_last_s1};
				end
			end else if (map_v_s1) begin
				skid_q <= '{mapped_pixel: map_rd_s1, out_last: map_last_s1};
				skid_v_q <= 1'b1;
			end
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

`ifndef SYNTH
	a_no_take_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_RUN |-> !in_ch.ready) else $error("item taken during build");
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q) else $error("skid full with empty output");
	a_div_only_build: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> state_q == ST_DIV) else $error("divider started outside build");
`endif
endmodule

// ===== test/histogram_equalizer_tb.sv =====
module histogram_equalizer_tb;
	import histeq_pkg::*;

	localparam int IDLE_MAX = 15;
	localparam int WATCHDOG_LIMIT = 40000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	histeq_in_if  in_ch ();
	histeq_out_if out_ch ();

	histogram_equalizer u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [COUNT_BITS-1:0] hist_bins [BIN_COUNT];
	logic [PIX_BITS-1:0]   equal_lut [BIN_COUNT];
	logic [COUNT_BITS-1:0] pix_count;

	in_item_t  pixel_queue[$];
	out_item_t mapped_expect[$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int builds_done = 0;
	bit stim_done = 1'b0;
	bit hold_sink = 1'b0;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// rebuild the mapping table from the cumulative histogram
	function automatic void build_lut();
		logic [63:0] acc, min_cdf, den, num, quo;
		logic [63:0] cdf [BIN_COUNT];
		bit found;
		acc = 0;
		min_cdf = 0;
		found = 1'b0;
		for (int i = 0; i < BIN_COUNT; i++) begin
			acc += hist_bins[i];
			cdf[i] = acc;
			if (!found && acc != 0) begin
				min_cdf = acc;
				found = 1'b1;
			end
		end
		builds_done++;
		if (min_cdf == pix_count) begin
			for (int i = 0; i < BIN_COUNT; i++)
				equal_lut[i] = i[PIX_BITS-1:0];
			return;
		end
		den = (pix_count > min_cdf) ? pix_count - min_cdf : 64'd1;
		for (int i = 0; i < BIN_COUNT; i++) begin
			if (cdf[i] < min_cdf) begin
				quo = 0;
			end else begin
				num = (cdf[i] - min_cdf) * 510 + den;
				quo = num / (2 * den);
				if (quo > 255)
					quo = 255;
			end
			equal_lut[i] = quo[PIX_BITS-1:0];
		end
	endfunction

	// expected results for one accepted item
	function automatic void predict_pixel(input in_item_t it);
		out_item_t res;
		if (it.func == FUNC_COUNT) begin
			if (hist_bins[it.pixel] != COUNT_MAX)
				hist_bins[it.pixel]++;
			if (pix_count != COUNT_MAX)
				pix_count++;
			if (it.frame_end) begin
				build_lut();
				for (int i = 0; i < BIN_COUNT; i++)
					hist_bins[i] = '0;
				pix_count = '0;
			end
		end else begin
			res.mapped_pixel = equal_lut[it.pixel];
			res.out_last = it.frame_end;
			mapped_expect.push_back(res);
		end
	endfunction

	function automatic in_item_t make_item(input logic f, input int p, input logic last);
		in_item_t it;
		it.func = f;
		it.pixel = p[PIX_BITS-1:0];
		it.frame_end = last;
		return it;
	endfunction

	// queue one frame: a count pass then a map pass of the same length
	task automatic push_frame(input int len, input int lo, input int hi);
		for (int i = 0; i < len; i++)
			pixel_queue.push_back(make_item(FUNC_COUNT, $urandom_range(hi, lo), i == len - 1));
		for (int i = 0; i < len; i++)
			pixel_queue.push_back(make_item(FUNC_MAP, $urandom_range(255, 0), i == len - 1));
	endtask

	task automatic wait_drained();
		while (pixel_queue.size() != 0 || in_ch.valid || mapped_expect.size() != 0)
			@(posedge clk);
	endtask

	// driver
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			send_gap <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_pixel(in_ch.data);
				items_sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0 || pixel_queue.size() == 0) begin
					in_ch.valid <= 1'b0;
					if (send_gap > 0)
						send_gap <= send_gap - 1;
				end else begin
					in_ch.valid <= 1'b1;
					in_ch.data <= pixel_queue.pop_front();
					send_gap <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(IDLE_MAX, 0);
				end
			end
		end
	end

	// monitor
	int recv_gap = 0;
	out_item_t got, want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				results_seen++;
				if (mapped_expect.size() == 0) begin
					report("unexpected result", got.mapped_pixel, -1);
				end else begin
					want = mapped_expect.pop_front();
					if (got.mapped_pixel !== want.mapped_pixel)
						report("mapped_pixel", got.mapped_pixel, want.mapped_pixel);
					if (got.out_last !== want.out_last)
						report("out_last", got.out_last, want.out_last);
				end
			end
			if (hold_sink) begin
				out_ch.ready <= 1'b0;
			end else if (out_ch.valid && out_ch.ready) begin
				recv_gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(IDLE_MAX, 0);
				out_ch.ready <= (recv_gap == 0);
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ch.ready <= (recv_gap == 0);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// long sink stall while the source keeps offering items
	initial begin
		int held;
		@(posedge arst_n);
		wait (builds_done >= 2);
		hold_sink <= 1'b1;
		held = 0;
		while (held < 400) begin
			@(posedge clk);
			held++;
		end
		hold_sink <= 1'b0;
	end

	// watchdog on progress
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", mapped_expect.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// stimulus
	initial begin
		int tail;
		for (int i = 0; i < BIN_COUNT; i++) begin
			hist_bins[i] = '0;
			equal_lut[i] = i[PIX_BITS-1:0];
		end
		pix_count = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// map before any build: identity table, both last flags
		pixel_queue.push_back(make_item(FUNC_MAP, 0, 1'b0));
		pixel_queue.push_back(make_item(FUNC_MAP, 255, 1'b0));
		pixel_queue.push_back(make_item(FUNC_MAP, 170, 1'b1));
		// uniform frame: identity table again
		pixel_queue.push_back(make_item(FUNC_COUNT, 85, 1'b0));
		pixel_queue.push_back(make_item(FUNC_COUNT, 85, 1'b1));
		pixel_queue.push_back(make_item(FUNC_MAP, 85, 1'b0));
		pixel_queue.push_back(make_item(FUNC_MAP, 200, 1'b1));
		// extremes with leading empty bins, halves rounding
		pixel_queue.push_back(make_item(FUNC_COUNT, 10, 1'b0));
		pixel_queue.push_back(make_item(FUNC_COUNT, 0, 1'b0));
		pixel_queue.push_back(make_item(FUNC_COUNT, 255, 1'b0));
		pixel_queue.push_back(make_item(FUNC_COUNT, 128, 1'b1));
		pixel_queue.push_back(make_item(FUNC_MAP, 0, 1'b0));
		pixel_queue.push_back(make_item(FUNC_MAP, 5, 1'b0));
		pixel_queue.push_back(make_item(FUNC_MAP, 10, 1'b0));
		pixel_queue.push_back(make_item(FUNC_MAP, 128, 1'b0));
		pixel_queue.push_back(make_item(FUNC_MAP, 255, 1'b1));
		// single-pixel frame
		pixel_queue.push_back(make_item(FUNC_COUNT, 255, 1'b1));
		pixel_queue.push_back(make_item(FUNC_MAP, 255, 1'b1));
		wait_drained();

		// random frames: mostly well formed, some broken passes
		while (items_sent < 500) begin
			case ($urandom_range(5, 0))
				0: push_frame($urandom_range(12, 1), 0, 255);
				1: push_frame($urandom_range(30, 2), 100, 110);
				2: begin
					for (int i = 0; i < 6; i++)
						pixel_queue.push_back(make_item($urandom_range(1, 0),
							$urandom_range(255, 0), $urandom_range(1, 0)));
				end
				default: push_frame($urandom_range(40, 4), 0, 255);
			endcase
			if ($urandom_range(4, 0) == 0)
				wait_drained();
			else
				while (pixel_queue.size() > 20)
					@(posedge clk);
		end
		wait_drained();
		stim_done = 1'b1;
		tail = 0;
		while (tail < 50) begin
			@(posedge clk);
			tail++;
		end
		$display("sent %0d pixels, %0d table builds, checked %0d mapped pixels",
			items_sent, builds_done, results_seen);
		if (errors == 0 && mapped_expect.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, mapped_expect.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
